### src/assert_macros.svh
// assertion macros used by the encoder tracker controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### src/ept_pkg.sv
// types and constants of the encoder position and velocity tracker
package ept_pkg;

   // request modes
   typedef enum logic [1:0] {
      MODE_UPDATE = 2'd0,
      MODE_SET    = 2'd1,
      MODE_RESET  = 2'd2
   } mode_type;

   // register indexes of the csr port
   localparam logic [2:0] REG_MAX_POSITION   = 3'd0;
   localparam logic [2:0] REG_PERIOD_US      = 3'd1;
   localparam logic [2:0] REG_VELOCITY_EN    = 3'd2;
   localparam logic [2:0] REG_REVERSE_DIR    = 3'd3;
   localparam logic [2:0] REG_DEADBAND       = 3'd4;
   localparam logic [2:0] REG_SPIKE_THRESH   = 3'd5;
   localparam logic [2:0] REG_FILTER_EN      = 3'd6;
   localparam logic [2:0] REG_ALPHA          = 3'd7;

   // velocity scaling: counts times one million over the period
   localparam logic [19:0] VelScale = 20'd1000000;
   localparam int          ProdW    = 52;
   localparam int          DivSteps = ProdW;
   localparam int          CntW     = 6;
   localparam logic [30:0] VelMax   = 31'h7FFF_FFFF;
   localparam logic [8:0]  AlphaOne = 9'd256;

   // controller states, one-hot
   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MODE  = 9'b000000010,
      ST_POS   = 9'b000000100,
      ST_DIV   = 9'b000001000,
      ST_COND  = 9'b000010000,
      ST_MUL   = 9'b000100000,
      ST_SUM   = 9'b001000000,
      ST_FILT  = 9'b010000000,
      ST_WRITE = 9'b100000000
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic mode_apply;
      logic pos_update;
      logic div_step;
      logic cond;
      logic mul;
      logic sum;
      logic filt;
      logic out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_update;
      logic speed_zero;
      logic filter_on;
   } stat_type;

endpackage

### src/ept_datapath.sv
// datapath: csr registers, position extension, divider, velocity filter
module ept_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  ept_pkg::cmd_type     cmd,
   output ept_pkg::stat_type    stat,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_write_data,
   input  logic [1:0]           req_mode,
   input  logic [31:0]          req_hw_position,
   input  logic [31:0]          req_raw_period_counts,
   input  logic                 req_hw_reverse,
   input  logic [31:0]          req_set_value,
   output logic signed [63:0]   rsp_position_count,
   output logic signed [31:0]   rsp_velocity_cps,
   output logic                 rsp_direction_reverse
);
   import ept_pkg::*;

   // configuration registers
   logic [31:0] max_position_ff;
   logic [31:0] period_us_ff;
   logic        velocity_enable_ff;
   logic        reverse_direction_ff;
   logic [30:0] deadband_ff;
   logic [30:0] spike_threshold_ff;
   logic        filter_enable_ff;
   logic [7:0]  alpha_ff;

   // captured request
   logic [1:0]  mode_ff;
   logic [31:0] hw_pos_ff;
   logic [31:0] counts_ff;
   logic        dir_ff;
   logic [31:0] set_value_ff;

   // tracker state
   logic [63:0]        acc_ff, acc_in;
   logic [31:0]        last_pos_ff, last_pos_in;
   logic signed [31:0] filt_ff, filt_in;

   // divider and filter working registers
   logic [ProdW-1:0]   dvd_ff, dvd_in;
   logic [31:0]        rem_ff, rem_in;
   logic signed [31:0] cand_ff, cand_in;
   logic signed [40:0] p1_ff;
   logic signed [41:0] sum_ff;

   // output registers
   logic [63:0]        out_pos_ff;
   logic signed [31:0] out_vel_ff;
   logic               out_dir_ff;

   // position extension signals
   logic [32:0]        wrap;
   logic [32:0]        half;
   logic signed [34:0] delta;
   logic signed [34:0] delta_adj;

   // divider step signals
   logic [32:0] rem_try;
   logic        q_bit;

   // conditioning signals
   logic [30:0]        mag;
   logic signed [31:0] raw_vel;
   logic signed [31:0] db_vel;
   logic signed [32:0] spike_diff;
   logic [32:0]        spike_abs;

   // filter signals
   logic [8:0]         a_eff;
   logic [8:0]         b_eff;
   logic signed [41:0] sum_in;
   logic signed [41:0] sum_bias;
   logic signed [41:0] sum_shift;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_position_ff      <= 32'hFFFF_FFFF;
         period_us_ff         <= '0;
         velocity_enable_ff   <= 1'b0;
         reverse_direction_ff <= 1'b0;
         deadband_ff          <= '0;
         spike_threshold_ff   <= '0;
         filter_enable_ff     <= 1'b0;
         alpha_ff             <= 8'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_MAX_POSITION: max_position_ff      <= csr_write_data;
            REG_PERIOD_US:    period_us_ff         <= csr_write_data;
            REG_VELOCITY_EN:  velocity_enable_ff   <= csr_write_data[0];
            REG_REVERSE_DIR:  reverse_direction_ff <= csr_write_data[0];
            REG_DEADBAND:     deadband_ff          <= csr_write_data[30:0];
            REG_SPIKE_THRESH: spike_threshold_ff   <= csr_write_data[30:0];
            REG_FILTER_EN:    filter_enable_ff     <= csr_write_data[0];
            REG_ALPHA:        alpha_ff             <= csr_write_data[7:0];
            default:          ;
         endcase
      end
   end

   // status to controller
   assign stat.is_update  = (mode_ff == MODE_UPDATE);
   assign stat.speed_zero = (period_us_ff == '0) || !velocity_enable_ff;
   assign stat.filter_on  = filter_enable_ff;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff      <= req_mode;
         hw_pos_ff    <= req_hw_position;
         counts_ff    <= req_raw_period_counts;
         dir_ff       <= req_hw_reverse ^ reverse_direction_ff;
         set_value_ff <= req_set_value;
      end
   end

   // half-range wrap of the raw position difference
   always_comb begin
      wrap  = {1'b0, max_position_ff} + 33'd1;
      half  = wrap >> 1;
      delta = $signed({3'b000, hw_pos_ff}) - $signed({3'b000, last_pos_ff});
      if (delta > $signed({2'b00, half})) begin
         delta_adj = delta - $signed({2'b00, wrap});
      end else if (delta < -$signed({2'b00, half})) begin
         delta_adj = delta + $signed({2'b00, wrap});
      end else begin
         delta_adj = delta;
      end
   end

   // restoring divide step
   always_comb begin
      rem_try = {rem_ff, dvd_ff[ProdW-1]};
      q_bit   = (rem_try >= {1'b0, period_us_ff});
   end

   // saturation, sign, deadband and spike rejection
   always_comb begin
      if (stat.speed_zero) begin
         mag = '0;
      end else if (dvd_ff > ProdW'(VelMax)) begin
         mag = VelMax;
      end else begin
         mag = dvd_ff[30:0];
      end
      raw_vel = dir_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      if ((deadband_ff != '0) && (mag < deadband_ff)) begin
         db_vel = '0;
      end else begin
         db_vel = raw_vel;
      end
      spike_diff = 33'(db_vel) - 33'(filt_ff);
      spike_abs  = spike_diff[32] ? 33'(-spike_diff) : 33'(spike_diff);
      if ((spike_threshold_ff != '0) && (spike_abs > {2'b00, spike_threshold_ff})) begin
         cand_in = filt_ff;
      end else begin
         cand_in = db_vel;
      end
   end

   // filter weights and rounding toward zero
   always_comb begin
      a_eff     = (alpha_ff == '0) ? 9'd1 : {1'b0, alpha_ff};
      b_eff     = AlphaOne - a_eff;
      sum_in    = 42'(p1_ff) + 42'($signed({1'b0, b_eff}) * filt_ff);
      sum_bias  = sum_ff[41] ? (sum_ff + 42'sd255) : sum_ff;
      sum_shift = sum_bias >>> 8;
   end

   // next values of the tracker state
   always_comb begin
      acc_in      = acc_ff;
      last_pos_in = last_pos_ff;
      filt_in     = filt_ff;
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      if (cmd.mode_apply) begin
         case (mode_ff)
            MODE_SET: begin
               acc_in      = {32'd0, set_value_ff};
               last_pos_in = set_value_ff;
            end
            MODE_RESET: begin
               acc_in      = '0;
               last_pos_in = '0;
               filt_in     = '0;
            end
            default: ;
         endcase
      end
      if (cmd.pos_update) begin
         acc_in      = acc_ff + 64'(delta_adj);
         last_pos_in = hw_pos_ff;
         dvd_in      = ProdW'(counts_ff * VelScale);
         rem_in      = '0;
      end
      if (cmd.div_step) begin
         rem_in = q_bit ? 32'(rem_try - {1'b0, period_us_ff}) : rem_try[31:0];
         dvd_in = {dvd_ff[ProdW-2:0], q_bit};
      end
      if (cmd.cond && !filter_enable_ff) begin
         filt_in = cand_in;
      end
      if (cmd.filt) begin
         filt_in = sum_shift[31:0];
      end
   end

   // tracker state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         last_pos_ff <= '0;
         filt_ff     <= '0;
      end else begin
         acc_ff      <= acc_in;
         last_pos_ff <= last_pos_in;
         filt_ff     <= filt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (cmd.cond) begin
         cand_ff <= cand_in;
      end
      if (cmd.mul) begin
         p1_ff <= 41'($signed({1'b0, a_eff}) * cand_ff);
      end
      if (cmd.sum) begin
         sum_ff <= sum_in;
      end
   end

   // output registers
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_pos_ff <= acc_ff;
         out_vel_ff <= filt_ff;
         out_dir_ff <= dir_ff;
      end
   end

   assign rsp_position_count    = $signed(out_pos_ff);
   assign rsp_velocity_cps      = out_vel_ff;
   assign rsp_direction_reverse = out_dir_ff;

endmodule

### src/ept_controller.sv
// controller: sequences one request through the datapath
`include "assert_macros.svh"

module ept_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ept_pkg::stat_type   stat,
   output ept_pkg::cmd_type    cmd
);
   import ept_pkg::*;

   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MODE;
            end
         end
         ST_MODE: begin
            // update requests run the full datapath, others apply at once
            if (stat.is_update) begin
               state_in = ST_POS;
            end else begin
               cmd.mode_apply = 1'b1;
               state_in       = ST_WRITE;
            end
         end
         ST_POS: begin
            cmd.pos_update = 1'b1;
            cnt_in         = '0;
            state_in       = stat.speed_zero ? ST_COND : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(DivSteps - 1)) begin
               state_in = ST_COND;
            end
         end
         ST_COND: begin
            cmd.cond = 1'b1;
            state_in = stat.filter_on ? ST_MUL : ST_WRITE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_FILT;
         end
         ST_FILT: begin
            cmd.filt = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // wait for the output register to free up
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // an accepted request always leaves idle
   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall, state_ff == ST_MODE)
   // a result load raises valid and returns to idle
   `ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.out_load, rsp_valid_ff && state_ff == ST_IDLE)
   // divide counter stays within the step count
   `ASSERT_IMPLIES(a_div_count_range, clock, reset, state_ff == ST_DIV, cnt_ff < CntW'(DivSteps))

endmodule

### src/encoder_position_velocity_tracker_core.sv
// top level of the encoder position and velocity tracker
// Usage:
//   Request channel (req_*): mode, raw counter position, counts of the last
//   velocity period, raw direction and a set value. A request is taken at a
//   clock edge with req_valid high and req_stall low.
//   Response channel (rsp_*): extended 64-bit position, filtered velocity in
//   counts per second and mapped direction, one response per request.
//   CSR port: csr_write_enable, csr_index and csr_write_data write one of
//   eight registers; write only while the block is idle.
// Sequencing: update requests run the position update, the 52-step restoring
//   divider, conditioning and, with the filter on, multiply, sum and filter
//   steps before the result loads; a zero period or velocity off skips the
//   divide. Set, reset and unused-mode requests go straight to the load. One
//   request is in work at a time; the next is taken the cycle after a
//   response loads, even while held.
// Reset: synchronous; position, last raw position and velocity clear to zero,
//   registers take their defaults, no response is pending.
// Stall: a stalled response holds in the output register; a finished request
//   then waits before loading it, and requests stall until it does.
module encoder_position_velocity_tracker_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic [31:0]         req_hw_position,
   input  logic [31:0]         req_raw_period_counts,
   input  logic                req_hw_reverse,
   input  logic [31:0]         req_set_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [63:0]  rsp_position_count,
   output logic signed [31:0]  rsp_velocity_cps,
   output logic                rsp_direction_reverse
);
   import ept_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   ept_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // arithmetic and state
   ept_datapath u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_mode              (req_mode),
      .req_hw_position       (req_hw_position),
      .req_raw_period_counts (req_raw_period_counts),
      .req_hw_reverse        (req_hw_reverse),
      .req_set_value         (req_set_value),
      .rsp_position_count    (rsp_position_count),
      .rsp_velocity_cps      (rsp_velocity_cps),
      .rsp_direction_reverse (rsp_direction_reverse)
   );

endmodule
